// ----- rtl/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// shared constants and types for the lru key/value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

    // default geometry
    localparam int DEF_ENTRIES    = 8;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 32;

    // operation codes carried in the request func field
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // outcome of one lookup in the tag store
    typedef struct packed {
        logic hit;      // key was present
        logic write;    // a put of a new key fills the chosen slot
        logic evicted;  // the least recent slot was displaced
    } t_tag_res;

endpackage

// ----- rtl/lkv_if.sv -----
// ----------------------------------------------------------------------------
// lkv_req_if / lkv_rsp_if
// valid/ready channels for cache requests and responses
// ----------------------------------------------------------------------------
interface lkv_req_if #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  func;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] new_value;

    modport source (output valid, output func, output lookup_key, output new_value,
                    input ready);
    modport sink   (input valid, input func, input lookup_key, input new_value,
                    output ready);
endinterface

interface lkv_rsp_if #(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;

    modport source (output valid, output hit, output read_value, output evicted,
                    input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    output ready);
endinterface

// ----- rtl/lkv_tags.sv -----
// ----------------------------------------------------------------------------
// lkv_tags
// key store, recency ranks, parallel match and lru replacement choice
// ----------------------------------------------------------------------------
module lkv_tags #(
    parameter int ENTRIES  = lkv_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = lkv_pkg::DEF_KEY_BITS,
    parameter int SLOT_BITS = $clog2(ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_func,
    input  logic [KEY_BITS-1:0]  i_key,
    output lkv_pkg::t_tag_res    o_res,
    output logic [SLOT_BITS-1:0] o_slot
);
    import lkv_pkg::*;

    localparam logic [SLOT_BITS-1:0] TOP_RANK = SLOT_BITS'(ENTRIES - 1);

    logic [KEY_BITS-1:0]  r_key  [ENTRIES];
    logic [SLOT_BITS-1:0] r_rank [ENTRIES];

    logic [ENTRIES-1:0]   match;
    logic [ENTRIES-1:0]   free;
    logic [SLOT_BITS-1:0] hit_idx;
    logic [SLOT_BITS-1:0] free_idx;
    logic [SLOT_BITS-1:0] lru_idx;
    logic [SLOT_BITS-1:0] target;
    logic [SLOT_BITS-1:0] target_rank;
    logic                 key_nz;
    logic                 hit;
    logic                 any_free;
    logic                 put_miss;
    logic                 promote;

    // per-slot compares
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (r_key[i] == i_key);
            free[i]  = (r_key[i] == '0);
        end
    end

    // lowest matching slot, lowest free slot, slot holding rank zero
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = SLOT_BITS'(i);
            end
            if (free[i]) begin
                free_idx = SLOT_BITS'(i);
            end
            if (r_rank[i] == '0) begin
                lru_idx = SLOT_BITS'(i);
            end
        end
    end

    // decision for this access
    always_comb begin
        key_nz      = (i_key != '0);
        hit         = key_nz && (|match);
        any_free    = |free;
        put_miss    = key_nz && (i_func == FUNC_PUT) && !hit;
        promote     = hit || put_miss;
        target      = hit ? hit_idx : (any_free ? free_idx : lru_idx);
        target_rank = r_rank[target];

        o_res.hit     = hit;
        o_res.write   = put_miss;
        o_res.evicted = put_miss && !any_free;
        o_slot        = target;
    end

    // key and rank update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_key[i]  <= '0;
                r_rank[i] <= SLOT_BITS'(i);
            end
        end else if (i_step) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (put_miss && (SLOT_BITS'(i) == target)) begin
                    r_key[i] <= i_key;
                end
                if (promote) begin
                    if (SLOT_BITS'(i) == target) begin
                        r_rank[i] <= TOP_RANK;
                    end else if (r_rank[i] > target_rank) begin
                        r_rank[i] <= r_rank[i] - 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key/value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
// One request beat is taken per clock while the response side is not stalled
// and is answered by exactly one response beat, in order. A request is
// captured in an input register; from there the key is compared against all
// ENTRIES slots in parallel, the recency ranks and the key store are updated,
// the value memory is read and written at the chosen slot, and the outcome
// lands in the response register. Both stages move together, so back-pressure
// on the response side stalls the request side only once both registers are
// full. A get of key 0 misses, a put of key 0 is ignored, a put of a present
// key keeps its stored value, and a put of a new key fills the lowest empty
// slot or evicts the least recent one.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES    = lkv_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lkv_req_if.sink  i_req,
    lkv_rsp_if.source o_rsp
);
    import lkv_pkg::*;

    localparam int SLOT_BITS = $clog2(ENTRIES);

    // input stage
    logic                  r_in_valid;
    logic                  r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;

    // response stage
    logic                  r_out_valid;
    logic                  r_hit;
    logic                  r_get_hit;
    logic                  r_evicted;
    logic [VALUE_BITS-1:0] r_rd;

    logic [VALUE_BITS-1:0] r_mem [ENTRIES];

    t_tag_res              tag_res;
    logic [SLOT_BITS-1:0]  slot;
    logic                  out_free;
    logic                  step;

    // stage handshakes
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign step        = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;

    // request capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_func <= i_req.func;
            r_key  <= i_req.lookup_key;
            r_val  <= i_req.new_value;
        end
    end

    // key store and replacement
    lkv_tags #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .SLOT_BITS (SLOT_BITS)
    ) u_tags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_func  (r_func),
        .i_key   (r_key),
        .o_res   (tag_res),
        .o_slot  (slot)
    );

    // value memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (step) begin
            if (tag_res.write) begin
                r_mem[slot] <= r_val;
            end
            r_rd <= r_mem[slot];
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_hit     <= tag_res.hit;
            r_get_hit <= tag_res.hit && (r_func == FUNC_GET);
            r_evicted <= tag_res.evicted;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_hit;
    assign o_rsp.read_value = r_get_hit ? r_rd : '0;
    assign o_rsp.evicted    = r_evicted;

endmodule

// ----- rtl/lkv_checker.sv -----
// ----------------------------------------------------------------------------
// lkv_checker
// port-level checks on the cache, bound to the top level
// ----------------------------------------------------------------------------
module lkv_checker #(
    parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic                  i_rsp_hit,
    input logic [VALUE_BITS-1:0] i_rsp_read_value,
    input logic                  i_rsp_evicted
);
    logic [2:0] r_pending;
    logic       req_beat;
    logic       rsp_beat;

    assign req_beat = i_req_valid && i_req_ready;
    assign rsp_beat = i_rsp_valid && i_rsp_ready;

    // requests accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 3'(req_beat) - 3'(rsp_beat);
        end
    end

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_hit)
            && $stable(i_rsp_read_value) && $stable(i_rsp_evicted))
        else $error("response changed while stalled");

    // a returned value comes only with a hit, never with an eviction
    a_value_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_read_value != '0) |-> i_rsp_hit && !i_rsp_evicted)
        else $error("value returned without a hit");

    // eviction only on a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_evicted |-> !i_rsp_hit)
        else $error("eviction reported on a hit");

    // every response answers an accepted request, at most two in flight
    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending <= 3'd2) && (!i_rsp_valid || (r_pending != '0)))
        else $error("response without a pending request");

endmodule

bind lru_key_value_cache lkv_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_lkv_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_hit        (o_rsp.hit),
    .i_rsp_read_value (o_rsp.read_value),
    .i_rsp_evicted    (o_rsp.evicted)
);
